### src/i2c_master_register_access_unit_macros.svh
// ----------------------------------------------------------------------------
// I2C master register access assertion macros
// Shared concurrent assertion forms, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define I2CMRA_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("i2c register access check failed");

`define I2CMRA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("i2c register access check failed");

`else

`define I2CMRA_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define I2CMRA_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

### src/i2cmra_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access package
// Item types, command and status codes, and the transaction programs.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

    typedef struct packed {
        logic       opcode;
        logic [1:0] kind;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       master_ack;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] read_data;
    } out_item_t;

    localparam logic OPCODE_TICK    = 1'b0;
    localparam logic OPCODE_COMMAND = 1'b1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_PROBE = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_ADDR_NACK  = 3'd1;
    localparam logic [2:0] STATUS_REG_NACK   = 3'd2;
    localparam logic [2:0] STATUS_RADDR_NACK = 3'd3;
    localparam logic [2:0] STATUS_DATA_NACK  = 3'd4;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd40;
    localparam logic [7:0] HALF_PERIOD_MIN   = 8'd2;
    localparam logic [3:0] PROG_LEN          = 4'd12;
    localparam logic [3:0] ACK_COUNT_MAX     = 4'd15;

    typedef enum logic [3:0] {
        OP_START,
        OP_WADDR,
        OP_WREG,
        OP_WDATA,
        OP_WADDRR,
        OP_ACK_ADDR,
        OP_ACK_REG,
        OP_ACK_RADDR,
        OP_ACK_DATA,
        OP_RBYTE,
        OP_MACK,
        OP_STOP,
        OP_END
    } op_t;

    function automatic op_t prog_op(input logic [1:0] kind, input logic [3:0] step);
        op_t op;
        op = OP_END;
        unique case (kind)
            KIND_WRITE:
            begin
                unique case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_WADDR;
                    4'd2:    op = OP_ACK_ADDR;
                    4'd3:    op = OP_WREG;
                    4'd4:    op = OP_ACK_REG;
                    4'd5:    op = OP_WDATA;
                    4'd6:    op = OP_ACK_DATA;
                    4'd7:    op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            KIND_READ:
            begin
                unique case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_WADDR;
                    4'd2:    op = OP_ACK_ADDR;
                    4'd3:    op = OP_WREG;
                    4'd4:    op = OP_ACK_REG;
                    4'd5:    op = OP_START;
                    4'd6:    op = OP_WADDRR;
                    4'd7:    op = OP_ACK_RADDR;
                    4'd8:    op = OP_RBYTE;
                    4'd9:    op = OP_MACK;
                    4'd10:   op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            KIND_PROBE:
            begin
                unique case (step)
                    4'd0:    op = OP_START;
                    4'd1:    op = OP_WADDR;
                    4'd2:    op = OP_ACK_ADDR;
                    default: op = OP_END;
                endcase
            end
            default:
            begin
                op = OP_END;
            end
        endcase
        return op;
    endfunction

    function automatic logic [2:0] ack_status(input op_t op);
        logic [2:0] code;
        unique case (op)
            OP_ACK_ADDR:  code = STATUS_ADDR_NACK;
            OP_ACK_REG:   code = STATUS_REG_NACK;
            OP_ACK_RADDR: code = STATUS_RADDR_NACK;
            default:      code = STATUS_DATA_NACK;
        endcase
        return code;
    endfunction

endpackage

### src/i2c_master_register_access_unit.sv
// ----------------------------------------------------------------------------
// I2C master register access unit
// Runs one register write, register read or busy probe per command and
// reports the SCL and SDA pin levels for every tick item.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  in        in_valid / in_ready       in_item  (i2cmra_pkg::in_item_t)
//  out       out_valid / out_ready     out_item (i2cmra_pkg::out_item_t)
//  cfg       cfg_we                    cfg_wdata (half period in ticks)
//
// One item is accepted per clock cycle while in_ready is high, and its
// result is registered in the next cycle; the sequencer update is one pass.
// Reset leaves the bus idle and the half period at 40 ticks.
// While out_ready is low a held result blocks in_ready, and input is
// accepted again in the same cycle that the held result is taken.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_unit_macros.svh"

module i2c_master_register_access_unit #(
    parameter int ACK_SAMPLES = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i2cmra_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2cmra_pkg::out_item_t out_item
);
    import i2cmra_pkg::*;

    localparam logic [7:0] ACK_LEN   = 8'(ACK_SAMPLES);
    localparam logic [3:0] NACK_ONES = 4'((ACK_SAMPLES > 1) ? ACK_SAMPLES - 1 : 1);

    logic [7:0] half_period_reg;
    logic       busy_reg,  busy_next;
    logic [3:0] step_reg,  step_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] tick_reg,  tick_next;
    logic [2:0] bit_reg,   bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] ack_reg,   ack_next;
    logic [1:0] kind_reg,  kind_next;
    logic [6:0] dev_reg,   dev_next;
    logic [7:0] rega_reg,  rega_next;
    logic [7:0] wdata_reg, wdata_next;
    logic       mack_reg,  mack_next;
    logic [2:0] status_reg, status_next;
    logic [7:0] rdata_reg,  rdata_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg, result;
    logic       in_fire;
    logic       done;
    logic       scl, sda, drive;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        logic       start;
        op_t        op;
        logic       is_write, is_ack;
        logic [7:0] byte_val;
        logic [7:0] len;
        logic [8:0] tick_inc;
        logic [1:0] last_phase;
        logic       seg_end;
        logic       byte_end;
        logic [3:0] step_inc;
        logic       finish_ok;

        start = !busy_reg && (in_item.opcode == OPCODE_COMMAND) && (in_item.kind != KIND_NONE);

        kind_next  = start ? in_item.kind : kind_reg;
        dev_next   = start ? in_item.device_address : dev_reg;
        rega_next  = start ? in_item.register_address : rega_reg;
        wdata_next = start ? in_item.write_data : wdata_reg;
        mack_next  = start ? in_item.master_ack : mack_reg;
        step_next  = start ? 4'd0 : step_reg;
        phase_next = start ? 2'd0 : phase_reg;
        tick_next  = start ? 8'd0 : tick_reg;
        bit_next   = start ? 3'd0 : bit_reg;
        shift_next = start ? 8'd0 : shift_reg;
        ack_next   = start ? 4'd0 : ack_reg;
        busy_next  = busy_reg || start;

        status_next = status_reg;
        rdata_next  = rdata_reg;
        done  = 1'b0;
        scl   = 1'b1;
        sda   = 1'b1;
        drive = 1'b0;

        op         = prog_op(kind_next, step_next);
        is_write   = (op == OP_WADDR) || (op == OP_WREG) || (op == OP_WDATA) ||
                     (op == OP_WADDRR);
        is_ack     = (op == OP_ACK_ADDR) || (op == OP_ACK_REG) || (op == OP_ACK_RADDR) ||
                     (op == OP_ACK_DATA);
        len        = (half_period_reg < HALF_PERIOD_MIN) ? HALF_PERIOD_MIN : half_period_reg;
        tick_inc   = {1'b0, tick_next} + 9'd1;
        last_phase = ((op == OP_START) || (op == OP_STOP)) ? 2'd2 : 2'd1;
        seg_end    = 1'b0;
        byte_end   = 1'b0;
        step_inc   = step_next + 4'd1;
        finish_ok  = 1'b0;

        unique case (op)
            OP_WADDR:  byte_val = {dev_next, 1'b0};
            OP_WADDRR: byte_val = {dev_next, 1'b1};
            OP_WREG:   byte_val = rega_next;
            default:   byte_val = wdata_next;
        endcase

        if (busy_next)
        begin
            unique case (op)
                OP_START:
                begin
                    scl   = (phase_next != 2'd0);
                    sda   = (phase_next != 2'd2);
                    drive = 1'b1;
                end
                OP_STOP:
                begin
                    scl   = (phase_next != 2'd0);
                    sda   = (phase_next == 2'd2);
                    drive = 1'b1;
                end
                OP_WADDR, OP_WREG, OP_WDATA, OP_WADDRR:
                begin
                    scl   = (phase_next != 2'd0);
                    sda   = byte_val[~bit_next];
                    drive = 1'b1;
                end
                OP_MACK:
                begin
                    scl   = (phase_next != 2'd0);
                    sda   = mack_next;
                    drive = 1'b1;
                end
                default:
                begin
                    scl   = (phase_next != 2'd0);
                    sda   = 1'b1;
                    drive = 1'b0;
                end
            endcase

            if (is_ack && (phase_next == 2'd1) && (len < ACK_LEN))
            begin
                len = ACK_LEN;
            end

            if (is_ack && (phase_next == 2'd1) && (tick_next >= len - ACK_LEN) &&
                in_item.sda_sample && (ack_next < ACK_COUNT_MAX))
            begin
                ack_next = ack_next + 4'd1;
            end

            if ((op == OP_RBYTE) && (phase_next == 2'd1) && (tick_inc == {1'b0, len}))
            begin
                shift_next = {shift_next[6:0], in_item.sda_sample};
            end

            if (tick_inc < {1'b0, len})
            begin
                tick_next = tick_inc[7:0];
            end
            else
            begin
                tick_next = 8'd0;
                if (phase_next < last_phase)
                begin
                    phase_next = phase_next + 2'd1;
                end
                else
                begin
                    phase_next = 2'd0;
                    seg_end    = 1'b1;
                end
            end

            if (seg_end && (is_write || (op == OP_RBYTE)))
            begin
                if (bit_next != 3'd7)
                begin
                    bit_next = bit_next + 3'd1;
                    seg_end  = 1'b0;
                end
                else
                begin
                    bit_next = 3'd0;
                    byte_end = 1'b1;
                end
            end

            if (byte_end && (op == OP_RBYTE))
            begin
                rdata_next = shift_next;
            end

            if (seg_end && is_ack)
            begin
                if (ack_next >= NACK_ONES)
                begin
                    done        = 1'b1;
                    status_next = ack_status(op);
                end
                ack_next = 4'd0;
            end

            if (seg_end && !done)
            begin
                step_next = step_inc;
                if ((step_inc >= PROG_LEN) || (prog_op(kind_next, step_inc) == OP_END))
                begin
                    finish_ok   = 1'b1;
                    done        = 1'b1;
                    status_next = STATUS_OK;
                end
            end

            if (done || finish_ok)
            begin
                busy_next  = 1'b0;
                step_next  = 4'd0;
                phase_next = 2'd0;
                tick_next  = 8'd0;
                bit_next   = 3'd0;
                ack_next   = 4'd0;
            end
        end

        result.scl_level = scl;
        result.sda_level = sda;
        result.sda_drive = drive;
        result.busy_res  = busy_next;
        result.done_res  = done;
        result.status    = status_next;
        result.read_data = rdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            half_period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= 4'd0;
            phase_reg  <= 2'd0;
            tick_reg   <= 8'd0;
            bit_reg    <= 3'd0;
            shift_reg  <= 8'd0;
            ack_reg    <= 4'd0;
            kind_reg   <= KIND_WRITE;
            dev_reg    <= 7'd0;
            rega_reg   <= 8'd0;
            wdata_reg  <= 8'd0;
            mack_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            rdata_reg  <= 8'd0;
        end
        else if (in_fire)
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            ack_reg    <= ack_next;
            kind_reg   <= kind_next;
            dev_reg    <= dev_next;
            rega_reg   <= rega_next;
            wdata_reg  <= wdata_next;
            mack_reg   <= mack_next;
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_item_reg <= result;
        end
    end

    `I2CMRA_ASSERT_IMPLIES(a_done_not_busy, clk, rst_n, out_valid && out_item.done_res, !out_item.busy_res)
    `I2CMRA_ASSERT_IMPLIES(a_idle_counters_clear, clk, rst_n, !busy_reg, (tick_reg == 8'd0) && (phase_reg == 2'd0) && (ack_reg == 4'd0) && (step_reg == 4'd0))
    `I2CMRA_ASSERT_NEXT(a_done_ends_busy, clk, rst_n, in_fire && done, !busy_reg)
    `I2CMRA_ASSERT_IMPLIES(a_idle_pins, clk, rst_n, out_valid && !out_item.busy_res && !out_item.done_res, out_item.scl_level && !out_item.sda_drive)

endmodule
